// ===== rtl/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the character LCD init and print block.
// ----------------------------------------------------------------------------
package clcd_pkg;

    // Default geometry of the display.
    localparam int COLUMNS_DEF = 16;
    localparam int ROWS_DEF    = 2;

    // Depth of the text store.
    localparam int STORE_DEPTH = 16;

    // Input command codes carried in tuser.
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_PRINT   = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    // Controller phases.
    typedef enum logic [2:0] {
        PH_BOOT  = 3'd0,
        PH_W1    = 3'd1,
        PH_W2    = 3'd2,
        PH_W3    = 3'd3,
        PH_SETUP = 3'd5,
        PH_IDLE  = 3'd6,
        PH_PRINT = 3'd7
    } t_phase;

    // Configuration register indexes.
    localparam logic [7:0] CFG_BOOT_DELAY  = 8'd0;
    localparam logic [7:0] CFG_FIRST_WAIT  = 8'd1;
    localparam logic [7:0] CFG_SHORT_WAIT  = 8'd2;
    localparam logic [7:0] CFG_DEVICE_ADDR = 8'd3;

    // Configuration reset values.
    localparam logic [15:0] BOOT_DELAY_RST  = 16'd50;
    localparam logic [7:0]  FIRST_WAIT_RST  = 8'd5;
    localparam logic [7:0]  SHORT_WAIT_RST  = 8'd1;
    localparam logic [6:0]  DEVICE_ADDR_RST = 7'd39;

    // LCD commands.
    localparam logic [7:0] LCD_WAKE_8BIT = 8'h30;
    localparam logic [7:0] LCD_WAKE_4BIT = 8'h20;
    localparam logic [2:0] SETUP_COUNT   = 3'd4;

    // Setup command sequence: function set, display on, entry mode, clear.
    function automatic logic [7:0] setup_cmd(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h28;
            2'd1: c = 8'h0C;
            2'd2: c = 8'h06;
            2'd3: c = 8'h01;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/char_lcd_i2c_init_and_print_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_i2c_init_and_print_top
// HD44780 4-bit controller behind an I2C port expander: power-up sequence,
// text buffer and print, one LCD byte sent as four expander byte beats.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+---------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser command, tdata fields
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tuser byte_valid, tlast, tdata
//  cfg      | in  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  Each input item is decoded in the cycle it is accepted; its results leave
//  the output register from the next cycle on: one beat, or four beats when
//  an LCD byte is sent. A new item is accepted while the final beat of the
//  previous run is taken, so items follow back to back while m_axis does not stall.
//  Reset is synchronous and active low; the text store is not cleared.
//  A stall on m_axis holds the current beat and blocks s_axis.
// ----------------------------------------------------------------------------
module char_lcd_i2c_init_and_print_top #(
    parameter int COLUMNS = clcd_pkg::COLUMNS_DEF,
    parameter int ROWS    = clcd_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: now_ms[31:0], bus_busy[32], char_code[40:33], row[42:41],
    // column[48:43], zero fill [55:49].
    input  logic [55:0] s_axis_tdata,
    // tuser: command[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: i2c_byte[7:0], target_address[14:8], accepted[15],
    // ready_res[16], zero fill [23:17].
    output logic [23:0] m_axis_tdata,
    // tuser: byte_valid[0].
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int          LIMIT    = (COLUMNS < clcd_pkg::STORE_DEPTH) ?
                                       COLUMNS : clcd_pkg::STORE_DEPTH;
    localparam logic [4:0]  LP_LIMIT = 5'(LIMIT);
    localparam logic [5:0]  LP_COLS  = 6'(COLUMNS);
    localparam logic [1:0]  LP_ROWS  = 2'(ROWS);

    // Configuration registers.
    logic [15:0] r_boot_delay;
    logic [7:0]  r_first_wait;
    logic [7:0]  r_short_wait;
    logic [6:0]  r_dev_addr;

    // Controller state.
    clcd_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_mark, n_mark;
    logic [2:0]  r_setup_idx, n_setup_idx;
    logic [4:0]  r_load_count, n_load_count;
    logic [4:0]  r_print_len, n_print_len;
    logic [4:0]  r_send_idx, n_send_idx;
    logic [7:0]  r_text [clcd_pkg::STORE_DEPTH];

    // Output run register.
    logic        r_out_valid;
    logic [1:0]  r_beat;
    logic        r_four;
    logic [7:0]  r_lcd_data;
    logic        r_rs;
    logic        r_acc;
    logic        r_ready_res;
    logic [6:0]  r_tgt_addr;

    // Decoded input fields.
    clcd_pkg::t_cmd w_cmd;
    logic [31:0] w_now;
    logic        w_busy;
    logic [7:0]  w_char;
    logic [1:0]  w_row;
    logic [5:0]  w_col;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_last_beat;
    logic [31:0] w_elapsed;
    logic        w_first_ok;
    logic        w_short_ok;
    logic        w_load_ok;
    logic        w_print_ok;

    // Results of the step.
    logic        n_emit;
    logic [7:0]  n_lcd_data;
    logic        n_rs;
    logic        n_acc;

    assign w_cmd    = clcd_pkg::t_cmd'(s_axis_tuser);
    assign w_now    = s_axis_tdata[31:0];
    assign w_busy   = s_axis_tdata[32];
    assign w_char   = s_axis_tdata[40:33];
    assign w_row    = s_axis_tdata[42:41];
    assign w_col    = s_axis_tdata[48:43];

    // Handshakes: input opens as the final beat of a run is taken.
    assign w_last_beat   = !r_four || (r_beat == 2'd3);
    assign w_out_acc     = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_out_valid || (m_axis_tready && w_last_beat);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Shared step conditions.
    assign w_elapsed  = w_now - r_mark;
    assign w_first_ok = !w_busy && (w_elapsed >= {24'd0, r_first_wait});
    assign w_short_ok = !w_busy && (w_elapsed >= {24'd0, r_short_wait});
    assign w_load_ok  = (r_phase == clcd_pkg::PH_IDLE) && (w_char != 8'd0) &&
                        (r_load_count < LP_LIMIT);
    assign w_print_ok = (r_phase == clcd_pkg::PH_IDLE) && (w_row < LP_ROWS) &&
                        (w_col < LP_COLS);

    // Next state of the controller.
    always_comb begin
        n_phase      = r_phase;
        n_mark       = r_mark;
        n_setup_idx  = r_setup_idx;
        n_load_count = r_load_count;
        n_print_len  = r_print_len;
        n_send_idx   = r_send_idx;
        unique case (w_cmd)
            clcd_pkg::CMD_TICK: begin
                unique case (r_phase)
                    clcd_pkg::PH_BOOT: begin
                        if (w_now > {16'd0, r_boot_delay}) begin
                            n_mark  = w_now;
                            n_phase = clcd_pkg::PH_W1;
                        end
                    end
                    clcd_pkg::PH_W1: begin
                        if (w_first_ok) begin
                            n_mark  = w_now;
                            n_phase = clcd_pkg::PH_W2;
                        end
                    end
                    clcd_pkg::PH_W2: begin
                        if (w_short_ok) begin
                            n_mark  = w_now;
                            n_phase = clcd_pkg::PH_W3;
                        end
                    end
                    clcd_pkg::PH_W3: begin
                        if (w_short_ok) begin
                            n_setup_idx = 3'd0;
                            n_phase     = clcd_pkg::PH_SETUP;
                        end
                    end
                    clcd_pkg::PH_SETUP: begin
                        if (!w_busy) begin
                            if (r_setup_idx < clcd_pkg::SETUP_COUNT) begin
                                n_setup_idx = r_setup_idx + 3'd1;
                            end else begin
                                n_phase = clcd_pkg::PH_IDLE;
                            end
                        end
                    end
                    clcd_pkg::PH_PRINT: begin
                        if (!w_busy) begin
                            if (r_send_idx < r_print_len) begin
                                n_send_idx = r_send_idx + 5'd1;
                            end else begin
                                n_phase = clcd_pkg::PH_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            clcd_pkg::CMD_LOAD: begin
                if (w_load_ok) begin
                    n_load_count = r_load_count + 5'd1;
                end
            end
            clcd_pkg::CMD_PRINT: begin
                if (w_print_ok) begin
                    n_print_len  = r_load_count;
                    n_load_count = 5'd0;
                    n_send_idx   = 5'd0;
                    n_phase      = clcd_pkg::PH_PRINT;
                end
            end
            clcd_pkg::CMD_RESTART: begin
                n_phase = clcd_pkg::PH_BOOT;
                n_mark  = 32'd0;
            end
        endcase
    end

    // Results of the step: whether an LCD byte goes out, and which.
    // Text characters are fetched from the store by the payload register.
    always_comb begin
        n_emit     = 1'b0;
        n_lcd_data = 8'd0;
        n_rs       = 1'b0;
        n_acc      = 1'b0;
        unique case (w_cmd)
            clcd_pkg::CMD_TICK: begin
                unique case (r_phase)
                    clcd_pkg::PH_W1: begin
                        n_emit     = w_first_ok;
                        n_lcd_data = clcd_pkg::LCD_WAKE_8BIT;
                    end
                    clcd_pkg::PH_W2: begin
                        n_emit     = w_short_ok;
                        n_lcd_data = clcd_pkg::LCD_WAKE_8BIT;
                    end
                    clcd_pkg::PH_W3: begin
                        n_emit     = w_short_ok;
                        n_lcd_data = clcd_pkg::LCD_WAKE_4BIT;
                    end
                    clcd_pkg::PH_SETUP: begin
                        n_emit     = !w_busy && (r_setup_idx < clcd_pkg::SETUP_COUNT);
                        n_lcd_data = clcd_pkg::setup_cmd(r_setup_idx[1:0]);
                    end
                    clcd_pkg::PH_PRINT: begin
                        n_emit     = !w_busy && (r_send_idx < r_print_len);
                        n_rs       = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            clcd_pkg::CMD_LOAD: begin
                n_acc = w_load_ok;
            end
            clcd_pkg::CMD_PRINT: begin
                // Set DDRAM address: row one starts at 0x40.
                n_emit     = w_print_ok;
                n_lcd_data = {1'b1, (w_row != 2'd0), w_col};
                n_acc      = w_print_ok;
            end
            clcd_pkg::CMD_RESTART: begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_delay <= clcd_pkg::BOOT_DELAY_RST;
            r_first_wait <= clcd_pkg::FIRST_WAIT_RST;
            r_short_wait <= clcd_pkg::SHORT_WAIT_RST;
            r_dev_addr   <= clcd_pkg::DEVICE_ADDR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == clcd_pkg::CFG_BOOT_DELAY)  r_boot_delay <= i_cfg_data;
            if (i_cfg_index == clcd_pkg::CFG_FIRST_WAIT)  r_first_wait <= i_cfg_data[7:0];
            if (i_cfg_index == clcd_pkg::CFG_SHORT_WAIT)  r_short_wait <= i_cfg_data[7:0];
            if (i_cfg_index == clcd_pkg::CFG_DEVICE_ADDR) r_dev_addr   <= i_cfg_data[6:0];
        end
    end

    // Controller state update on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= clcd_pkg::PH_BOOT;
            r_mark       <= 32'd0;
            r_setup_idx  <= 3'd0;
            r_load_count <= 5'd0;
            r_print_len  <= 5'd0;
            r_send_idx   <= 5'd0;
        end else if (w_in_acc) begin
            r_phase      <= n_phase;
            r_mark       <= n_mark;
            r_setup_idx  <= n_setup_idx;
            r_load_count <= n_load_count;
            r_print_len  <= n_print_len;
            r_send_idx   <= n_send_idx;
        end
    end

    // Text store, written by accepted loads.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_cmd == clcd_pkg::CMD_LOAD) && w_load_ok) begin
            r_text[r_load_count[3:0]] <= w_char;
        end
    end

    // Output run control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_beat      <= 2'd0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
            r_beat      <= 2'd0;
        end else if (w_out_acc) begin
            if (w_last_beat) begin
                r_out_valid <= 1'b0;
            end else begin
                r_beat <= r_beat + 2'd1;
            end
        end
    end

    // Output run payload, captured with the item. A text beat reads the
    // character at the send pointer straight from the store.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_four      <= n_emit;
            r_lcd_data  <= n_rs ? r_text[r_send_idx[3:0]] : n_lcd_data;
            r_rs        <= n_rs;
            r_acc       <= n_acc;
            r_ready_res <= (n_phase == clcd_pkg::PH_IDLE);
            r_tgt_addr  <= r_dev_addr;
        end
    end

    // Expander byte of the current beat: nibble, backlight, enable, RS.
    logic [3:0] w_nibble;
    logic       w_en;
    logic [7:0] w_byte;

    assign w_nibble = r_beat[1] ? r_lcd_data[3:0] : r_lcd_data[7:4];
    assign w_en     = !r_beat[0];
    assign w_byte   = r_four ? {w_nibble, 1'b1, w_en, 1'b0, r_rs} : 8'd0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_ready_res, r_acc, r_tgt_addr, w_byte};
    assign m_axis_tuser  = r_four;
    assign m_axis_tlast  = w_last_beat;

`ifndef ASSERT_OFF
    // A pending non-final beat keeps the input closed.
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !w_last_beat) |-> !s_axis_tready)
        else $error("input accepted in the middle of a four-beat run");

    // Status beats carry no byte and always end the run.
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'd0)))
        else $error("status beat not final or carries a byte");

    // The send pointer never runs past the print length.
    a_send_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_send_idx <= r_print_len)
        else $error("send index beyond print length");

    // The load count and the print length stay within the buffer limit.
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_count <= LP_LIMIT) && (r_print_len <= LP_LIMIT))
        else $error("text count beyond buffer limit");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the character LCD init and print block. Items go in
// on the input stream and configuration writes on the register channel, and
// every beat that comes out is checked against a behavioral predictor that
// tracks the power-up phases, the text buffer and the print state. The bench
// runs directed power-up, text and register cases, a long output stall, and
// then random bring-up and print sessions under random configurations.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COLS       = clcd_pkg::COLUMNS_DEF;
    localparam int ROWS       = clcd_pkg::ROWS_DEF;
    localparam int TEXT_LIMIT = (COLS < clcd_pkg::STORE_DEPTH) ? COLS :
                                clcd_pkg::STORE_DEPTH;

    // Expander bit positions.
    localparam logic [7:0] EXP_RS = 8'h01;
    localparam logic [7:0] EXP_EN = 8'h04;
    localparam logic [7:0] EXP_BL = 8'h08;

    // HD44780 commands.
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_CLEAR        = 8'h01;
    localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] LCD_ROW1_BASE    = 8'h40;
    localparam logic [3:0][7:0] SETUP_SEQUENCE =
        {LCD_CLEAR, LCD_ENTRY_MODE, LCD_DISPLAY_ON, LCD_FUNCTION_SET};

    // One output beat as the block presents it.
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       byte_valid;
        logic [6:0] address;
        logic       run_last;
        logic       accepted;
        logic       idle;
    } t_expander_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Predictor state: controller phase, timing and text buffer.
    clcd_pkg::t_phase lcd_phase = clcd_pkg::PH_BOOT;
    logic [31:0] mark_ms      = '0;
    logic [2:0]  setup_idx    = '0;
    logic [7:0]  text_mem [clcd_pkg::STORE_DEPTH];
    logic [4:0]  load_cnt     = '0;
    logic [4:0]  print_len    = '0;
    logic [4:0]  send_idx     = '0;
    logic [15:0] cfg_boot     = clcd_pkg::BOOT_DELAY_RST;
    logic [7:0]  cfg_first    = clcd_pkg::FIRST_WAIT_RST;
    logic [7:0]  cfg_short    = clcd_pkg::SHORT_WAIT_RST;
    logic [6:0]  cfg_addr     = clcd_pkg::DEVICE_ADDR_RST;

    t_expander_beat pending_beats [$];
    int             error_count   = 0;
    int             items_sent    = 0;
    bit             quiet_run     = 1'b0;
    int             stall_request = 0;
    logic [31:0]    lcd_time_ms   = '0;

    char_lcd_i2c_init_and_print_top #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Work out the beats caused by one accepted item and queue them.
    task automatic predict_expander_beats(input clcd_pkg::t_cmd cmd,
                                          input logic [31:0] now_ms,
                                          input logic busy, input logic [7:0] char_code,
                                          input logic [1:0] row, input logic [5:0] column);
        logic           emit;
        logic [7:0]     lcd_data;
        logic [7:0]     rs;
        logic           acc;
        logic [31:0]    elapsed;
        logic [7:0]     hi;
        logic [7:0]     lo;
        t_expander_beat beat;
        emit     = 1'b0;
        lcd_data = '0;
        rs       = '0;
        acc      = 1'b0;
        elapsed  = now_ms - mark_ms;
        case (cmd)
            clcd_pkg::CMD_TICK: begin
                case (lcd_phase)
                    clcd_pkg::PH_BOOT: begin
                        if (now_ms > 32'(cfg_boot)) begin
                            mark_ms   = now_ms;
                            lcd_phase = clcd_pkg::PH_W1;
                        end
                    end
                    clcd_pkg::PH_W1: begin
                        if (!busy && elapsed >= 32'(cfg_first)) begin
                            mark_ms   = now_ms;
                            lcd_phase = clcd_pkg::PH_W2;
                            emit      = 1'b1;
                            lcd_data  = clcd_pkg::LCD_WAKE_8BIT;
                        end
                    end
                    clcd_pkg::PH_W2: begin
                        if (!busy && elapsed >= 32'(cfg_short)) begin
                            mark_ms   = now_ms;
                            lcd_phase = clcd_pkg::PH_W3;
                            emit      = 1'b1;
                            lcd_data  = clcd_pkg::LCD_WAKE_8BIT;
                        end
                    end
                    clcd_pkg::PH_W3: begin
                        if (!busy && elapsed >= 32'(cfg_short)) begin
                            setup_idx = '0;
                            lcd_phase = clcd_pkg::PH_SETUP;
                            emit      = 1'b1;
                            lcd_data  = clcd_pkg::LCD_WAKE_4BIT;
                        end
                    end
                    clcd_pkg::PH_SETUP: begin
                        if (!busy) begin
                            if (setup_idx < 3'(clcd_pkg::SETUP_COUNT)) begin
                                emit      = 1'b1;
                                lcd_data  = SETUP_SEQUENCE[setup_idx[1:0]];
                                setup_idx = setup_idx + 3'd1;
                            end else begin
                                lcd_phase = clcd_pkg::PH_IDLE;
                            end
                        end
                    end
                    clcd_pkg::PH_PRINT: begin
                        if (!busy) begin
                            if (send_idx < print_len) begin
                                emit     = 1'b1;
                                rs       = EXP_RS;
                                lcd_data = text_mem[send_idx[3:0]];
                                send_idx = send_idx + 5'd1;
                            end else begin
                                lcd_phase = clcd_pkg::PH_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            clcd_pkg::CMD_LOAD: begin
                if (lcd_phase == clcd_pkg::PH_IDLE && char_code != 8'd0 &&
                    load_cnt < TEXT_LIMIT) begin
                    text_mem[load_cnt[3:0]] = char_code;
                    load_cnt = load_cnt + 5'd1;
                    acc      = 1'b1;
                end
            end
            clcd_pkg::CMD_PRINT: begin
                if (lcd_phase == clcd_pkg::PH_IDLE && row < ROWS && column < COLS) begin
                    lcd_data  = LCD_SET_DDRAM |
                                ((8'(column) + ((row != 2'd0) ? LCD_ROW1_BASE : 8'h00))
                                 & 8'h7F);
                    print_len = load_cnt;
                    load_cnt  = '0;
                    send_idx  = '0;
                    lcd_phase = clcd_pkg::PH_PRINT;
                    emit      = 1'b1;
                    acc       = 1'b1;
                end
            end
            default: begin
                lcd_phase = clcd_pkg::PH_BOOT;
                mark_ms   = '0;
            end
        endcase

        // Status fields shared by every beat of this item.
        beat.byte_valid = emit;
        beat.address    = cfg_addr;
        beat.accepted   = acc;
        beat.idle       = (lcd_phase == clcd_pkg::PH_IDLE);
        if (emit) begin
            hi = (lcd_data & 8'hF0) | EXP_BL | rs;
            lo = {lcd_data[3:0], 4'h0} | EXP_BL | rs;
            beat.run_last = 1'b0;
            beat.lcd_byte = hi | EXP_EN;
            pending_beats.push_back(beat);
            beat.lcd_byte = hi;
            pending_beats.push_back(beat);
            beat.lcd_byte = lo | EXP_EN;
            pending_beats.push_back(beat);
            beat.lcd_byte = lo;
            beat.run_last = 1'b1;
            pending_beats.push_back(beat);
        end else begin
            beat.lcd_byte = '0;
            beat.run_last = 1'b1;
            pending_beats.push_back(beat);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Check output beats, predict accepted items and track register writes.
    always @(posedge i_clk) begin : beat_check
        t_expander_beat want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_beats.size() == 0) begin
                    $error("output beat %0h with no expected beat waiting", m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_beats.pop_front();
                    check_field("i2c_byte", want.lcd_byte, m_axis_tdata[7:0]);
                    check_field("byte_valid", want.byte_valid, m_axis_tuser);
                    check_field("target_address", want.address, m_axis_tdata[14:8]);
                    check_field("last_of_run", want.run_last, m_axis_tlast);
                    check_field("accepted", want.accepted, m_axis_tdata[15]);
                    check_field("ready_res", want.idle, m_axis_tdata[16]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_expander_beats(clcd_pkg::t_cmd'(s_axis_tuser), s_axis_tdata[31:0],
                                       s_axis_tdata[32], s_axis_tdata[40:33],
                                       s_axis_tdata[42:41], s_axis_tdata[48:43]);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    clcd_pkg::CFG_BOOT_DELAY:  cfg_boot  = i_cfg_data;
                    clcd_pkg::CFG_FIRST_WAIT:  cfg_first = i_cfg_data[7:0];
                    clcd_pkg::CFG_SHORT_WAIT:  cfg_short = i_cfg_data[7:0];
                    clcd_pkg::CFG_DEVICE_ADDR: cfg_addr  = i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result receiver: random idling, or a long hold-off when one is requested.
    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request != 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet_run || ($urandom_range(99) >= 17);
            end
        end
    end

    // Offer one item and hold it until the block takes the beat.
    task automatic send_item(input clcd_pkg::t_cmd cmd, input logic [31:0] now_ms,
                             input logic busy, input logic [7:0] char_code,
                             input logic [1:0] row, input logic [5:0] column);
        @(negedge i_clk);
        if (!quiet_run && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, column, row, char_code, busy, now_ms};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_tick(input logic [31:0] now_ms, input logic busy);
        send_item(clcd_pkg::CMD_TICK, now_ms, busy, 8'($urandom), 2'($urandom),
                  6'($urandom));
    endtask

    task automatic send_load(input logic [7:0] char_code);
        send_item(clcd_pkg::CMD_LOAD, $urandom, 1'($urandom), char_code, 2'($urandom),
                  6'($urandom));
    endtask

    task automatic send_print(input logic [1:0] row, input logic [5:0] column);
        send_item(clcd_pkg::CMD_PRINT, $urandom, 1'($urandom), 8'($urandom), row, column);
    endtask

    task automatic send_restart();
        send_item(clcd_pkg::CMD_RESTART, $urandom, 1'($urandom), 8'($urandom),
                  2'($urandom), 6'($urandom));
    endtask

    task automatic write_register(input logic [7:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering items and wait until every expected beat has arrived.
    task automatic wait_for_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One timed wake-up nibble, optionally preceded by an early and a busy tick.
    task automatic wake_step(input logic [7:0] wait_ms, input bit rough);
        if (rough && wait_ms != 8'd0 && $urandom_range(1) == 1)
            send_tick(lcd_time_ms + 32'($urandom_range(0, wait_ms - 1)), 1'b0);
        if (rough && $urandom_range(2) == 0)
            send_tick(lcd_time_ms + 32'(wait_ms), 1'b1);
        lcd_time_ms = lcd_time_ms + 32'(wait_ms) + 32'($urandom_range(0, rough ? 20 : 0));
        send_tick(lcd_time_ms, 1'b0);
    endtask

    // Restart and walk the whole power-up up to idle.
    task automatic bring_up(input logic [31:0] start_ms, input bit rough);
        send_restart();
        if (rough)
            send_tick(32'($urandom_range(0, cfg_boot)), 1'($urandom));
        lcd_time_ms = (start_ms > 32'(cfg_boot)) ? start_ms : 32'(cfg_boot) + 32'd1;
        send_tick(lcd_time_ms, 1'($urandom));
        wake_step(cfg_first, rough);
        wake_step(cfg_short, rough);
        wake_step(cfg_short, rough);
        repeat (5) begin
            if (rough && $urandom_range(3) == 0)
                send_tick($urandom, 1'b1);
            send_tick($urandom, 1'b0);
        end
    endtask

    // Load some text, in rough runs try an illegal position, print it at a legal one and tick it out.
    task automatic print_text(input int count, input bit rough);
        repeat (count)
            send_load((rough && $urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        if (rough) begin
            if ($urandom_range(1) == 1)
                send_print(2'($urandom_range(ROWS, 3)), 6'($urandom));
            else
                send_print(2'($urandom), 6'($urandom_range(COLS, 63)));
        end
        send_print(2'($urandom_range(0, ROWS - 1)), 6'($urandom_range(0, COLS - 1)));
        repeat (count + 2) begin
            if (rough && $urandom_range(3) == 0)
                send_tick($urandom, 1'b1);
            if (rough && $urandom_range(7) == 0)
                send_load(8'($urandom));
            send_tick($urandom, 1'b0);
        end
    endtask

    // Power-up with reset settings: boot edge, early and busy ticks, setup.
    task automatic test_power_up_sequence();
        send_load(8'h41);
        send_print(2'd0, 6'd0);
        send_tick(32'd0, 1'b0);
        send_tick(32'd50, 1'b1);
        send_tick(32'd51, 1'b0);
        send_tick(32'd55, 1'b0);
        send_tick(32'd56, 1'b1);
        send_tick(32'd56, 1'b0);
        send_tick(32'd56, 1'b0);
        send_tick(32'd57, 1'b0);
        send_tick(32'd57, 1'b1);
        send_tick(32'd58, 1'b0);
        repeat (4) send_tick(32'hFFFF_FFFF, 1'b0);
        send_tick(32'd0, 1'b1);
        send_tick(32'd0, 1'b0);
        wait_for_idle();
    endtask

    // Loads, rejected positions, printing, empty print and restart.
    task automatic test_text_and_print();
        send_load(8'h00);
        send_load(8'hFF);
        send_load(8'h01);
        send_load(8'hA5);
        send_print(2'd2, 6'd0);
        send_print(2'd0, 6'd16);
        send_print(2'd3, 6'd63);
        send_print(2'd1, 6'd15);
        send_load(8'h42);
        send_print(2'd0, 6'd0);
        send_tick($urandom, 1'b1);
        repeat (4) send_tick($urandom, 1'b0);
        send_print(2'd0, 6'd0);
        send_tick($urandom, 1'b0);
        // A loaded character must survive the restart.
        send_load(8'h7E);
        send_restart();
        send_tick(32'd10, 1'b0);
        wait_for_idle();
    endtask

    // Register extremes, masking, an unused index and time wrap-around.
    task automatic test_config_extremes();
        write_register(clcd_pkg::CFG_BOOT_DELAY, 16'hFFFF);
        write_register(clcd_pkg::CFG_FIRST_WAIT, 16'hFFFF);
        write_register(clcd_pkg::CFG_SHORT_WAIT, 16'h00FF);
        write_register(clcd_pkg::CFG_DEVICE_ADDR, 16'hFFFF);
        bring_up(32'hFFFF_FF80, 1'b1);
        print_text(1, 1'b0);
        wait_for_idle();
        write_register(clcd_pkg::CFG_BOOT_DELAY, 16'h0000);
        write_register(clcd_pkg::CFG_FIRST_WAIT, 16'hFF00);
        write_register(clcd_pkg::CFG_SHORT_WAIT, 16'h0000);
        write_register(clcd_pkg::CFG_DEVICE_ADDR, 16'h0000);
        write_register(8'hFF, 16'hFFFF);
        bring_up(32'd0, 1'b1);
        print_text(2, 1'b1);
        wait_for_idle();
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_output_backpressure();
        stall_request = 300;
        bring_up($urandom, 1'b0);
        print_text(4, 1'b0);
        wait_for_idle();
    endtask

    // Random configurations and sessions, mostly well-formed with some noise.
    // The first session runs with no idling on either side.
    task automatic test_random_sessions();
        int first_item;
        int session;
        first_item = items_sent;
        session    = 0;
        while (items_sent - first_item < 50) begin
            wait_for_idle();
            write_register(clcd_pkg::CFG_BOOT_DELAY, 16'($urandom));
            write_register(clcd_pkg::CFG_FIRST_WAIT, 16'($urandom));
            write_register(clcd_pkg::CFG_SHORT_WAIT, 16'($urandom));
            write_register(clcd_pkg::CFG_DEVICE_ADDR, 16'($urandom));
            write_register(8'($urandom_range(4, 255)), 16'($urandom));
            quiet_run = (session == 0);
            bring_up($urandom, $urandom_range(3) != 0);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(5) == 0)
                    print_text($urandom_range(15, 18), $urandom_range(1) == 1);
                else
                    print_text($urandom_range(0, 4), $urandom_range(1) == 1);
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(clcd_pkg::t_cmd'($urandom_range(3)), $urandom, 1'($urandom),
                              8'($urandom), 2'($urandom), 6'($urandom));
            end
            session++;
        end
        wait_for_idle();
        quiet_run = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = clcd_pkg::CMD_TICK;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up_sequence();
        test_text_and_print();
        test_config_extremes();
        test_output_backpressure();
        test_random_sessions();

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake or beats that never arrive.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
